@@ rtl/core/swv_pkg.sv @@
// Shared constants and types for the sliding window variance block.
// Used by swv_div, sliding_window_variance_stability and the bench; no dependencies.
package swv_pkg;

  localparam int unsigned WINDOW_SIZE = 16;

  localparam int unsigned IDX_W  = $clog2(WINDOW_SIZE);
  localparam int unsigned CNT_W  = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned SUM_W  = SMP_W + CNT_W;          // signed window sum
  localparam int unsigned SQ_W   = 2 * SMP_W - 1;          // one sample squared
  localparam int unsigned SSQ_W  = SQ_W + CNT_W;           // sum of squares
  localparam int unsigned NSQ_W  = SSQ_W + CNT_W;          // count * sum of squares
  localparam int unsigned NUM_W  = 2 * SUM_W;              // variance numerator
  localparam int unsigned DIV_W  = SUM_W;                  // divider dividend (|sum|)
  localparam int unsigned DVS_W  = CNT_W;                  // divider divisor (count)
  localparam int unsigned ITER_W = $clog2(DIV_W + 1);

  localparam int unsigned VAR_W  = 31;
  localparam logic [VAR_W-1:0] VAR_MAX   = {VAR_W{1'b1}};
  localparam logic [VAR_W-1:0] THR_RESET = VAR_W'(65536);

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_req_t;

endpackage

@@ rtl/core/swv_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on swv_pkg for widths and the request struct.
module swv_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  swv_pkg::div_req_t        req_i,
  input  logic [swv_pkg::DIV_W-1:0] dividend_i,
  input  logic [swv_pkg::DVS_W-1:0] divisor_i,
  output logic [swv_pkg::DIV_W-1:0] quotient_o,
  output logic                     done_o
);
  import swv_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [ITER_W-1:0] cnt_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DIV_W-1:0]  quo_q;

  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    diff;
  logic              ge;
  logic [DVS_W-1:0]  rem_d;

  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = (shifted >= {1'b0, dvs_q});
    // remainder stays below the divisor, so the top bit is always zero
    rem_d   = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.iters;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == ITER_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

@@ rtl/core/sliding_window_variance_stability.sv @@
// Top level of the sliding window variance and stability detector.
// Depends on swv_pkg and swv_div.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries action_i and sample_i.
//   action_i = 0 stores a signed Q8.8 sample in a 16-entry ring and reports
//   mean, population variance, fill count and stability; action_i = 1
//   empties the window and reports all zeros.
//   Output channel (out_valid_o / out_ready_i) returns one result per request.
//   Config channel (cfg_valid_i / cfg_ready_o, cfg_data_i) writes the Q16.16
//   variance threshold; it is always ready and is meant to be written idle.
// Timing:
//   One request at a time. The window is summed through the ring memory
//   port, then the divider forms the mean. With a full window the variance
//   follows: two multiplies, then subtract and scale by the constant
//   window size squared. The divider, one quotient bit per cycle, is the
//   longest step.
// Reset clears fill count, write position and threshold (65536); ring
// contents are not cleared and are only read once written. If the receiver
// stalls, the result waits in the output register and the next request is
// already taken and worked on; it waits at its end for the register.
module sliding_window_variance_stability (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic signed [15:0]         sample_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [swv_pkg::VAR_W-1:0]  cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       stable_o,
  output logic                       window_full_o,
  output logic signed [15:0]         mean_o,
  output logic [swv_pkg::VAR_W-1:0]  variance_o,
  output logic [4:0]                 fill_count_o
);
  import swv_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACC   = 3'd1;
  localparam logic [2:0] S_MDIV  = 3'd2;
  localparam logic [2:0] S_VMUL1 = 3'd3;
  localparam logic [2:0] S_VMUL2 = 3'd4;
  localparam logic [2:0] S_VSUB  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [CNT_W-1:0] CNT_FULL    = CNT_W'(WINDOW_SIZE);
  localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(WINDOW_SIZE - 1);

  logic [2:0]              state_q, state_d;
  logic [IDX_W-1:0]        wpos_q;
  logic [CNT_W-1:0]        count_q;
  logic [CNT_W-1:0]        iss_q;
  logic                    rd_v_q;
  logic                    pr_v_q;
  logic                    clr_q;
  logic [VAR_W-1:0]        thr_q;

  logic signed [SMP_W-1:0] ring_mem [WINDOW_SIZE];
  logic signed [SMP_W-1:0] rd_data_q;
  logic [SQ_W-1:0]         prod_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SSQ_W-1:0]        sumsq_q;
  logic [NSQ_W-1:0]        nsq_q;
  logic [NUM_W-1:0]        magsq_q;
  logic signed [15:0]      mean_q;
  logic [VAR_W-1:0]        var_res_q;

  logic                    out_valid_q;
  logic                    stable_q;
  logic                    full_q;
  logic signed [15:0]      mean_out_q;
  logic [VAR_W-1:0]        var_out_q;
  logic [4:0]              fill_q;

  logic                    in_acc;
  logic                    issue;
  logic                    acc_done;
  logic                    full_w;
  logic                    out_free;
  logic                    sum_neg;
  logic [SUM_W-1:0]        sum_mag;
  logic signed [2*SMP_W-1:0] sq_full;
  logic [NSQ_W-1:0]        nsq_w;
  logic [NUM_W-1:0]        magsq_w;
  logic [NUM_W:0]          num_diff;
  logic [NUM_W-1:0]        num_w;
  logic [NUM_W-1:0]        var_quot;
  logic [SUM_W-1:0]        mean_mag;
  logic [SUM_W-1:0]        mean_signed;

  div_req_t                div_req;
  logic [DIV_W-1:0]        div_dividend;
  logic [DIV_W-1:0]        div_quot;
  logic [DVS_W-1:0]        div_divisor;
  logic                    div_done;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign issue    = (state_q == S_ACC) && (iss_q < count_q);
  assign acc_done = (iss_q == count_q) && !rd_v_q && !pr_v_q;
  assign full_w   = (count_q == CNT_FULL);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sum_neg     = sum_q[SUM_W-1];
    sum_mag     = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    sq_full     = (2*SMP_W)'(rd_data_q) * (2*SMP_W)'(rd_data_q);
    nsq_w       = NSQ_W'(sumsq_q) * NSQ_W'(count_q);
    magsq_w     = NUM_W'(sum_mag) * NUM_W'(sum_mag);
    num_diff    = {1'b0, NUM_W'(nsq_q)} - {1'b0, magsq_q};
    num_w       = num_diff[NUM_W] ? '0 : num_diff[NUM_W-1:0];
    // only reached with a full window, so count^2 is a constant
    var_quot    = num_w / NUM_W'(WINDOW_SIZE * WINDOW_SIZE);
    mean_mag    = div_quot[SUM_W-1:0];
    mean_signed = sum_neg ? (~mean_mag + 1'b1) : mean_mag;
  end

  // divider: |sum| / count for the mean
  always_comb begin
    div_req.start = (state_q == S_ACC) && acc_done;
    div_req.iters = ITER_W'(DIV_W);
    div_dividend  = sum_mag;
    div_divisor   = count_q;
  end

  swv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quot),
    .done_o     (div_done)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = action_i ? S_FIN : S_ACC;
      S_ACC:   if (acc_done) state_d = S_MDIV;
      S_MDIV:  if (div_done) state_d = full_w ? S_VMUL1 : S_FIN;
      S_VMUL1: state_d = S_VMUL2;
      S_VMUL2: state_d = S_VSUB;
      S_VSUB:  state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wpos_q      <= '0;
      count_q     <= '0;
      iss_q       <= '0;
      rd_v_q      <= 1'b0;
      pr_v_q      <= 1'b0;
      clr_q       <= 1'b0;
      thr_q       <= THR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) thr_q <= cfg_data_i;
      if (in_acc) begin
        clr_q  <= action_i;
        iss_q  <= '0;
        rd_v_q <= 1'b0;
        pr_v_q <= 1'b0;
        if (action_i) begin
          count_q <= '0;
          wpos_q  <= '0;
        end else begin
          wpos_q <= (wpos_q == IDX_LAST) ? '0 : wpos_q + 1'b1;
          if (!full_w) count_q <= count_q + 1'b1;
        end
      end else if (state_q == S_ACC) begin
        if (issue) iss_q <= iss_q + 1'b1;
        rd_v_q <= issue;
        pr_v_q <= rd_v_q;
      end
      if ((state_q == S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ring memory: one write port at request time, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc && !action_i) ring_mem[wpos_q] <= sample_i;
    if (issue) rd_data_q <= ring_mem[iss_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sum_q   <= '0;
      sumsq_q <= '0;
    end else if (state_q == S_ACC) begin
      prod_q <= sq_full[SQ_W-1:0];
      if (rd_v_q) sum_q <= sum_q + SUM_W'(rd_data_q);
      if (pr_v_q) sumsq_q <= sumsq_q + SSQ_W'(prod_q);
    end
    if ((state_q == S_MDIV) && div_done) mean_q <= mean_signed[15:0];
    if (state_q == S_VMUL1) nsq_q <= nsq_w;
    if (state_q == S_VMUL2) magsq_q <= magsq_w;
    if (state_q == S_VSUB) begin
      var_res_q <= (var_quot > NUM_W'(VAR_MAX)) ? VAR_MAX : var_quot[VAR_W-1:0];
    end
    if ((state_q == S_FIN) && out_free) begin
      if (clr_q) begin
        stable_q   <= 1'b0;
        full_q     <= 1'b0;
        mean_out_q <= '0;
        var_out_q  <= '0;
        fill_q     <= '0;
      end else begin
        stable_q   <= full_w && (var_res_q < thr_q);
        full_q     <= full_w;
        mean_out_q <= mean_q;
        var_out_q  <= full_w ? var_res_q : VAR_MAX;
        fill_q     <= 5'(count_q);
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign stable_o      = stable_q;
  assign window_full_o = full_q;
  assign mean_o        = mean_out_q;
  assign variance_o    = var_out_q;
  assign fill_count_o  = fill_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("fill count beyond window size");

  a_add_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !action_i) |=> (count_q != '0) && (state_q == S_ACC))
    else $error("added sample did not enter the window");

  a_not_full_unstable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !window_full_o) |-> !stable_o)
    else $error("stable reported with window not full");

  a_not_full_var: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !window_full_o && (fill_count_o != '0)) |-> (variance_o == VAR_MAX))
    else $error("variance not saturated while filling");

endmodule

@@ dv/tb_sliding_window_variance_stability.sv @@
// Self-checking bench for sliding_window_variance_stability: directed and random
// sample runs, checked against an in-bench window predictor.
// Depends on swv_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_sliding_window_variance_stability;
  import swv_pkg::*;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;
  localparam int   STALL_LIMIT = 3000;
  localparam int   PHASE_REQS  = 300;
  localparam int   NUM_PHASES  = 6;

  typedef struct packed {
    logic               action;
    logic signed [15:0] sample;
  } window_req_t;

  typedef struct packed {
    logic               stable;
    logic               full;
    logic signed [15:0] mean;
    logic [VAR_W-1:0]   variance;
    logic [4:0]         fill;
  } window_stats_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     action_i = ACT_ADD;
  logic signed [15:0]       sample_i = '0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [VAR_W-1:0]         cfg_data_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic                     stable_o;
  logic                     window_full_o;
  logic signed [15:0]       mean_o;
  logic [VAR_W-1:0]         variance_o;
  logic [4:0]               fill_count_o;

  sliding_window_variance_stability u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .sample_i      (sample_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .stable_o      (stable_o),
    .window_full_o (window_full_o),
    .mean_o        (mean_o),
    .variance_o    (variance_o),
    .fill_count_o  (fill_count_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Predictor state
  logic signed [15:0] held_samples [WINDOW_SIZE];
  int unsigned        next_slot = 0;
  int unsigned        held_cnt = 0;
  logic [VAR_W-1:0]   stable_limit = THR_RESET;

  window_req_t   req_q [$];
  window_stats_t stats_expected_q [$];
  int            error_count = 0;
  int            idle_cycles = 0;
  bit            req_taken = 1'b0;
  bit            res_taken = 1'b0;

  function automatic window_stats_t update_window(logic act, logic signed [15:0] smp);
    window_stats_t st;
    longint        sum;
    longint        sumsq;
    longint        n;
    longint        num;
    longint        q;
    st = '0;
    if (act == ACT_CLEAR) begin
      held_cnt  = 0;
      next_slot = 0;
      return st;
    end
    held_samples[next_slot] = smp;
    next_slot = (next_slot + 1) % WINDOW_SIZE;
    if (held_cnt < WINDOW_SIZE) held_cnt++;
    sum   = 0;
    sumsq = 0;
    // slots 0..held_cnt-1 are always the written ones
    for (int i = 0; i < held_cnt; i++) begin
      sum   += longint'(held_samples[i]);
      sumsq += longint'(held_samples[i]) * longint'(held_samples[i]);
    end
    n = held_cnt;
    st.mean = 16'(sum / n);
    st.fill = 5'(held_cnt);
    st.full = (held_cnt == WINDOW_SIZE);
    if (st.full) begin
      num = n * sumsq - sum * sum;
      if (num < 0) num = 0;
      q = num / (n * n);
      if (q > longint'(VAR_MAX)) q = longint'(VAR_MAX);
      st.variance = VAR_W'(q);
      st.stable   = (q < longint'(stable_limit));
    end else begin
      st.variance = VAR_MAX;
      st.stable   = 1'b0;
    end
    return st;
  endfunction

  task automatic check_stats(window_stats_t exp_st);
    if (stable_o !== exp_st.stable) begin
      $error("stable: expected %0d, got %0d", exp_st.stable, stable_o);
      error_count++;
    end
    if (window_full_o !== exp_st.full) begin
      $error("window_full: expected %0d, got %0d", exp_st.full, window_full_o);
      error_count++;
    end
    if (mean_o !== exp_st.mean) begin
      $error("mean: expected %0d, got %0d", exp_st.mean, mean_o);
      error_count++;
    end
    if (variance_o !== exp_st.variance) begin
      $error("variance: expected %0d, got %0d", exp_st.variance, variance_o);
      error_count++;
    end
    if (fill_count_o !== exp_st.fill) begin
      $error("fill_count: expected %0d, got %0d", exp_st.fill, fill_count_o);
      error_count++;
    end
  endtask

  // Monitor: handshakes sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin : mon
      bit active;
      active = 1'b0;
      if (in_valid_i && in_ready_o) begin
        stats_expected_q.push_back(update_window(action_i, sample_i));
        req_taken = 1'b1;
        active = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        stable_limit = cfg_data_i;
        active = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (stats_expected_q.size() == 0) begin
          $error("result with no request pending");
          error_count++;
        end else begin
          check_stats(stats_expected_q.pop_front());
        end
        res_taken = 1'b1;
        active = 1'b1;
      end
      idle_cycles = active ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin : drive_req
      window_req_t cur;
      int          send_gap;
      int          burst_left;
      bit          no_idle;
      if (in_valid_i && !req_taken) begin
        // hold until accepted
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (req_q.size() != 0) begin
        cur = req_q.pop_front();
        action_i   <= cur.action;
        sample_i   <= cur.sample;
        in_valid_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(20, 60);
          no_idle = ($urandom_range(0, 3) == 0);
        end
        burst_left--;
        send_gap = no_idle ? 0 : $urandom_range(0, 10);
      end else begin
        in_valid_i <= 1'b0;
      end
      req_taken = 1'b0;
    end
  end

  // Result receiver: stall drawn when a new result shows up
  always @(negedge clk_i) begin
    if (rst_ni) begin : drive_rdy
      int recv_stall;
      int burst_left;
      bit no_idle;
      bit stall_drawn;
      if (res_taken) begin
        res_taken = 1'b0;
        stall_drawn = 1'b0;
      end
      if (out_valid_o && !stall_drawn && !out_ready_i) begin
        stall_drawn = 1'b1;
      end else if (out_valid_o && !stall_drawn) begin
        stall_drawn = 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(20, 60);
          no_idle = ($urandom_range(0, 3) == 0);
        end
        burst_left--;
        recv_stall = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic push_req(logic act, logic signed [15:0] smp);
    window_req_t r;
    r.action = act;
    r.sample = smp;
    req_q.push_back(r);
  endtask

  // Run of samples around a base with a chosen spread; spread < 0 means full range
  task automatic push_run(int unsigned len);
    int spread;
    int base;
    int v;
    base = int'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 5))
      0:       spread = 0;
      1:       spread = 1;
      2:       spread = 15;
      3:       spread = 255;
      4:       spread = 4095;
      default: spread = -1;
    endcase
    repeat (len) begin
      if (spread < 0) v = int'($urandom_range(0, 65535)) - 32768;
      else v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      push_req(ACT_ADD, 16'(v));
    end
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid_i || stats_expected_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_limit(logic [VAR_W-1:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [VAR_W-1:0] phase_limit(int ph);
    case (ph)
      0:       return VAR_MAX;
      1:       return '0;
      2:       return VAR_W'(1);
      3:       return VAR_W'($urandom_range(0, 1 << 24));
      4:       return VAR_W'($urandom);
      default: return VAR_W'(65536);
    endcase
  endfunction

  initial begin
    int start_len;
    int phase_reqs;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset threshold, empty clear, extremes, truncation toward zero,
    // max-spread full window with wrap, clear of a full window
    push_req(ACT_CLEAR, 16'sh7FFF);
    push_req(ACT_ADD, 16'sh7FFF);
    push_req(ACT_ADD, -16'sh8000);
    push_req(ACT_ADD, 16'sh0001);
    push_req(ACT_ADD, -16'sh0001);
    for (int i = 0; i < 14; i++)
      push_req(ACT_ADD, (i % 2) ? 16'sh7FFF : -16'sh8000);
    push_req(ACT_CLEAR, '0);
    for (int i = 0; i < 5; i++)
      push_req(ACT_ADD, -16'sh0003);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_limit(phase_limit(ph));
      phase_reqs = 0;
      while (phase_reqs < PHASE_REQS) begin
        start_len = req_q.size();
        if ($urandom_range(0, 3) == 0) push_req(ACT_CLEAR, 16'($urandom));
        // short runs cut by a clear are the noise part
        if ($urandom_range(0, 4) == 0) begin
          push_run($urandom_range(1, 15));
          push_req(ACT_CLEAR, 16'($urandom));
        end else begin
          push_run($urandom_range(16, 40));
        end
        phase_reqs += req_q.size() - start_len;
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (100) @(negedge clk_i);
    if (error_count == 0 && stats_expected_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ sliding_window_variance_stability.f @@
rtl/core/swv_pkg.sv
rtl/core/swv_div.sv
rtl/core/sliding_window_variance_stability.sv
dv/tb_sliding_window_variance_stability.sv
